[rtl/lge_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_pkg
// Shared types and constants for the life generation engine: command and
// result beats, operation codes, register indexes and the neighbor window.
// ----------------------------------------------------------------------------
package lge_pkg;

  // Grid size defaults
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // Configuration port
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // Operation codes
  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_ADVANCE = 2'd2;

  // Rule B3/S23 neighbor counts
  localparam logic [3:0] COUNT_KEEP  = 4'd2;
  localparam logic [3:0] COUNT_BIRTH = 4'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic       cell_value;
  } item_t;

  typedef struct packed {
    logic read_value;
    logic bad_coordinate;
  } result_t;

  // Three-by-three window around one cell: [2] east, [1] center, [0] west
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] here;
    logic [2:0] below;
  } window_t;

endpackage

[rtl/lge_cell_rule.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_cell_rule
// Shared cell unit: counts the eight neighbors of one cell and applies
// rule B3/S23. Used once per cell during an advance.
// ----------------------------------------------------------------------------
module lge_cell_rule
  import lge_pkg::*;
(
  input  window_t win,
  output logic    alive
);

  logic [3:0] count;

  // Sum the eight neighbors, center excluded
  always_comb begin
    count = 4'(win.above[0]) + 4'(win.above[1]) + 4'(win.above[2])
          + 4'(win.here[0])  + 4'(win.here[2])
          + 4'(win.below[0]) + 4'(win.below[1]) + 4'(win.below[2]);
  end

  // Alive on three, survive on two, die otherwise
  always_comb begin
    if (count == COUNT_BIRTH) begin
      alive = 1'b1;
    end else if (count == COUNT_KEEP) begin
      alive = win.here[1];
    end else begin
      alive = 1'b0;
    end
  end

endmodule

[rtl/life_generation_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_generation_engine
// Game of Life (B3/S23) on a bounded grid of one-bit cells with write, read
// and advance commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low.
//   Each command gives exactly one result beat, shown on result for one
//   cycle with done high; the receiver cannot stall it.
//   A read or write of a cell in range passes through a cell update state
//   before done; an out-of-range coordinate or no-op code gives done
//   straight from idle. An advance loads the first row from the grid RAM,
//   then for each row in use fetches the row below where there is one,
//   passes every one of its MAX_COLS columns through the single cell-rule
//   unit, one per cycle, then writes the row back. busy stays high through
//   an in-range read or write and an advance, so one command runs at a time.
//   Size registers are written through cfg_we / cfg_index / cfg_data. The user
//   must write them only while the block is idle; the block does not enforce
//   it. Values of 0 act as 1, values above the grid clamp. Reset sets both to
//   64; a clearing pass writes every grid row dead, one per cycle, busy high.
// ----------------------------------------------------------------------------
module life_generation_engine
  import lge_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int CIDX_W = $clog2(MAX_COLS);
  localparam int RCNT_W = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W = $clog2(MAX_COLS + 1);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_CELL_UPD = 9'b000000100,
    S_PRIME_LD = 9'b000001000,
    S_ROW_RD   = 9'b000010000,
    S_ROW_LD   = 9'b000100000,
    S_SCAN     = 9'b001000000,
    S_ROW_WR   = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t                  state;
  logic [CFG_DATA_W-1:0]   rows_in_use;
  logic [CFG_DATA_W-1:0]   cols_in_use;
  logic [RCNT_W-1:0]       nr;
  logic [CCNT_W-1:0]       nc;
  logic [RIDX_W-1:0]       r;
  logic [CIDX_W-1:0]       c;
  item_t                   cmd;

  logic [MAX_COLS-1:0]     grid [MAX_ROWS];
  logic                    mem_re;
  logic [RIDX_W-1:0]       mem_raddr;
  logic [MAX_COLS-1:0]     mem_rdata;
  logic                    mem_we;
  logic [RIDX_W-1:0]       mem_waddr;
  logic [MAX_COLS-1:0]     mem_wdata;

  logic [MAX_COLS-1:0]     above_sh;
  logic [MAX_COLS-1:0]     here_sh;
  logic [MAX_COLS-1:0]     below_sh;
  logic [MAX_COLS-1:0]     res_sh;
  logic                    prev_above;
  logic                    prev_here;
  logic                    prev_below;

  logic                    accept;
  logic                    is_cell_op;
  logic                    bad_in;
  logic                    below_in;
  logic                    right_in;
  logic                    col_in_use;
  logic [MAX_COLS-1:0]     row_mod;
  logic [CIDX_W-1:0]       cmd_col;
  logic [RIDX_W-1:0]       cmd_row;
  window_t                 win;
  logic                    rule_alive;
  logic                    new_bit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Clamp the size registers to the grid
  always_comb begin
    if (rows_in_use == '0) begin
      nr = RCNT_W'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      nr = RCNT_W'(MAX_ROWS);
    end else begin
      nr = RCNT_W'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      nc = CCNT_W'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      nc = CCNT_W'(MAX_COLS);
    end else begin
      nc = CCNT_W'(cols_in_use);
    end
  end

  // Decode the incoming command
  assign is_cell_op = (item.func == FUNC_WRITE) || (item.func == FUNC_READ);
  assign bad_in     = (32'(item.row) >= 32'(nr)) || (32'(item.col) >= 32'(nc));

  // Row and column bounds during an advance
  assign below_in   = (RCNT_W'(r) + RCNT_W'(1)) < nr;
  assign right_in   = (CCNT_W'(c) + CCNT_W'(1)) < nc;
  assign col_in_use = CCNT_W'(c) < nc;

  assign cmd_col = CIDX_W'(cmd.col);
  assign cmd_row = RIDX_W'(cmd.row);

  // Merge the written cell into its row
  always_comb begin
    row_mod          = mem_rdata;
    row_mod[cmd_col] = cmd.cell_value;
  end

  // Gather the window for the current column
  always_comb begin
    win.above = {right_in ? above_sh[1] : 1'b0, above_sh[0], prev_above};
    win.here  = {right_in ? here_sh[1]  : 1'b0, here_sh[0],  prev_here};
    win.below = {right_in ? below_sh[1] : 1'b0, below_sh[0], prev_below};
  end

  lge_cell_rule u_rule (
    .win   (win),
    .alive (rule_alive)
  );

  // Columns beyond the size in use keep their contents
  assign new_bit = col_in_use ? rule_alive : here_sh[0];

  // Steer the grid RAM ports
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = RIDX_W'(item.row);
    mem_we    = 1'b0;
    mem_waddr = r;
    mem_wdata = '0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        if (accept && is_cell_op && !bad_in) begin
          mem_re = 1'b1;
        end else if (accept && item.func == FUNC_ADVANCE) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
        end
      end
      S_ROW_RD: begin
        mem_re    = below_in;
        mem_raddr = r + RIDX_W'(1);
      end
      S_CELL_UPD: begin
        mem_we    = (cmd.func == FUNC_WRITE);
        mem_waddr = cmd_row;
        mem_wdata = row_mod;
      end
      S_ROW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = res_sh;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Grid RAM, one row per entry, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= grid[mem_raddr];
    end
  end

  // Sequencer and size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      r           <= '0;
      c           <= '0;
      done        <= 1'b0;
      rows_in_use <= SIZE_RESET;
      cols_in_use <= SIZE_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_IN_USE: rows_in_use <= cfg_data;
          REG_COLS_IN_USE: cols_in_use <= cfg_data;
          default:         rows_in_use <= rows_in_use;
        endcase
      end
      case (state)
        S_CLEAR: begin
          if (r == RIDX_W'(MAX_ROWS - 1)) begin
            r     <= '0;
            state <= S_IDLE;
          end else begin
            r <= r + RIDX_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (is_cell_op && !bad_in) begin
              state <= S_CELL_UPD;
            end else if (item.func == FUNC_ADVANCE) begin
              state <= S_PRIME_LD;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_CELL_UPD: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_PRIME_LD: begin
          r     <= '0;
          state <= S_ROW_RD;
        end
        S_ROW_RD: begin
          state <= S_ROW_LD;
        end
        S_ROW_LD: begin
          c     <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          c <= c + CIDX_W'(1);
          if (c == CIDX_W'(MAX_COLS - 1)) begin
            state <= S_ROW_WR;
          end
        end
        S_ROW_WR: begin
          if (below_in) begin
            r     <= r + RIDX_W'(1);
            state <= S_ROW_RD;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: command hold, row shifters and result beat
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd                   <= item;
          result.read_value     <= 1'b0;
          result.bad_coordinate <= is_cell_op && bad_in;
        end
      end
      S_CELL_UPD: begin
        result.read_value     <= (cmd.func == FUNC_READ) ? mem_rdata[cmd_col] : 1'b0;
        result.bad_coordinate <= 1'b0;
      end
      S_PRIME_LD: begin
        here_sh  <= mem_rdata;
        above_sh <= '0;
      end
      S_ROW_LD: begin
        below_sh   <= below_in ? mem_rdata : '0;
        prev_above <= 1'b0;
        prev_here  <= 1'b0;
        prev_below <= 1'b0;
      end
      S_SCAN: begin
        // Rotate so each row is back in place after a full pass
        above_sh   <= {above_sh[0], above_sh[MAX_COLS-1:1]};
        here_sh    <= {here_sh[0], here_sh[MAX_COLS-1:1]};
        below_sh   <= {below_sh[0], below_sh[MAX_COLS-1:1]};
        prev_above <= above_sh[0];
        prev_here  <= here_sh[0];
        prev_below <= below_sh[0];
        res_sh     <= {new_bit, res_sh[MAX_COLS-1:1]};
      end
      S_ROW_WR: begin
        above_sh <= here_sh;
        here_sh  <= below_sh;
        result   <= '0;
      end
      default: begin
        cmd <= cmd;
      end
    endcase
  end

endmodule

[rtl/lge_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_checker
// Port-level checks on the life generation engine, bound to the top level.
// ----------------------------------------------------------------------------
module lge_checker
  import lge_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input item_t   item,
  input logic    done,
  input result_t result
);

  // A result beat only follows an accepted beat or a running command
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start && !busy))
    else $error("result beat without a command");

  // The result beat ends the command
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result beat while still busy");

  // A read value and an error flag never come together
  a_result_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.read_value && result.bad_coordinate))
    else $error("read value on a bad coordinate");

  // An advance never finishes in the cycle after its accept
  a_advance_runs: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func == FUNC_ADVANCE) |=> (busy && !done))
    else $error("advance ended early");

  // The clearing pass holds the block busy after reset
  a_clear_busy: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy during clearing pass");

endmodule

bind life_generation_engine lge_checker u_lge_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
